// ----- sv/dqs_pkg.sv -----
// shared types and constants for the double-ended queue with search
// no dependencies
`default_nettype none

package dqs_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_DROP_FRONT = 3'd2,
        REQ_DROP_BACK  = 3'd3,
        REQ_SEARCH     = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef struct packed {
        logic en;
        t_req req;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- sv/double_ended_queue_with_search.sv -----
// bounded double-ended queue with search, built as a row of shifting cells
// result: the cells register the compare, then find-first loads the output register
// throughput: one request per cycle; a held result stalls input once the pending stage fills
// reset: synchronous active-low i_rst_n clears occupancy, cell valid flags and handshakes
// depends on dqs_pkg, dqs_cell, dqs_ffs
`default_nettype none

module double_ended_queue_with_search #(
    parameter int CAPACITY   = dqs_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = dqs_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [dqs_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic signed [dqs_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [dqs_pkg::STATUS_W-1:0]        o_status,
    output logic [dqs_pkg::POS_W-1:0]           o_found_index,
    output logic [dqs_pkg::POS_W-1:0]           o_occupancy_now
);
    import dqs_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic                  acc;
    logic                  p_move;
    t_req                  req;
    logic signed [63:0]    value_ext;
    logic [VALUE_BITS-1:0] key;
    logic                  empty;
    logic                  full;
    logic                  op_en;
    logic                  op_search;
    t_status               op_status;
    t_cell_ctl             ctl;

    logic [OCC_W-1:0]      r_occ;
    logic [OCC_W-1:0]      n_occ;
    logic                  r_p_valid;
    logic                  r_p_search;
    t_status               r_p_status;
    logic [OCC_W-1:0]      r_p_occ;

    logic                  r_o_valid;
    t_status               r_o_status;
    logic [POS_W-1:0]      r_o_idx;
    logic [POS_W-1:0]      r_o_occ;

    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   cell_match;
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W:0]        hit_pos;

    assign req       = t_req'(i_req_type);
    assign value_ext = 64'(i_value);
    assign key       = value_ext[VALUE_BITS-1:0];
    assign empty     = (r_occ == '0);
    assign full      = (r_occ == OCC_W'(CAPACITY));

    assign p_move     = r_p_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_p_valid || p_move;
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_occ     = r_occ;
        op_en     = 1'b0;
        op_search = 1'b0;
        op_status = ST_OK;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (full) begin
                    op_status = ST_FULL;
                end else begin
                    op_en = 1'b1;
                    n_occ = r_occ + OCC_W'(1);
                end
            end
            REQ_DROP_FRONT, REQ_DROP_BACK: begin
                if (empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    op_en = 1'b1;
                    n_occ = r_occ - OCC_W'(1);
                end
            end
            REQ_SEARCH: begin
                if (empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    op_en     = 1'b1;
                    op_search = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign ctl.en  = acc && op_en;
    assign ctl.req = req;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_BITS-1:0] left_value;
        logic                  left_valid;
        logic [VALUE_BITS-1:0] right_value;
        logic                  right_valid;

        if (i == 0) begin : g_front
            assign left_value = key;
            assign left_valid = 1'b1;
        end else begin : g_mid_l
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1) begin : g_back
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid_r
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        dqs_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_key         (key),
            .i_left_value  (left_value),
            .i_left_valid  (left_valid),
            .i_right_value (right_value),
            .i_right_valid (right_valid),
            .o_value       (cell_value[i]),
            .o_valid       (cell_valid[i]),
            .o_match       (cell_match[i])
        );
    end

    dqs_ffs #(
        .N(CAPACITY)
    ) u_ffs (
        .i_match (cell_match),
        .o_found (hit),
        .o_index (hit_idx)
    );

    assign hit_pos = (IDX_W + 1)'(hit_idx) + (IDX_W + 1)'(1);

    // pending stage holds the request while the cells register the compare
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_search <= op_search;
            r_p_status <= op_status;
            r_p_occ    <= n_occ;
        end
        if (p_move) begin
            if (r_p_search) begin
                r_o_status <= hit ? ST_OK : ST_MISS;
                r_o_idx    <= hit ? POS_W'(hit_pos) : '0;
            end else begin
                r_o_status <= r_p_status;
                r_o_idx    <= '0;
            end
            r_o_occ <= POS_W'(r_p_occ);
        end
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_occ <= n_occ;
            end
            if (acc) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_found_index   = r_o_idx;
    assign o_occupancy_now = r_o_occ;

endmodule

`default_nettype wire

// ----- sv/dqs_cell.sv -----
// one storage cell of the queue: value, valid flag and registered match
// depends on dqs_pkg
`default_nettype none

module dqs_cell #(
    parameter int VALUE_BITS = dqs_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire dqs_pkg::t_cell_ctl    i_ctl,
    input  wire logic [VALUE_BITS-1:0] i_key,
    input  wire logic [VALUE_BITS-1:0] i_left_value,
    input  wire logic                  i_left_valid,
    input  wire logic [VALUE_BITS-1:0] i_right_value,
    input  wire logic                  i_right_valid,
    output logic [VALUE_BITS-1:0]      o_value,
    output logic                       o_valid,
    output logic                       o_match
);
    import dqs_pkg::*;

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;
    logic                  r_valid;
    logic                  n_valid;
    logic                  r_match;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.en) begin
            case (i_ctl.req)
                REQ_PUSH_FRONT: begin
                    n_value = i_left_value;
                    n_valid = i_left_valid;
                end
                REQ_PUSH_BACK: begin
                    if (!r_valid && i_left_valid) begin
                        n_value = i_key;
                        n_valid = 1'b1;
                    end
                end
                REQ_DROP_FRONT: begin
                    n_value = i_right_value;
                    n_valid = i_right_valid;
                end
                REQ_DROP_BACK: begin
                    if (r_valid && !i_right_valid) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctl.en && i_ctl.req == REQ_SEARCH) begin
            r_match <= r_valid && (r_value == i_key);
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ----- sv/dqs_ffs.sv -----
// find-first-set tree over the cell match flags, lowest index wins
// depends on dqs_pkg
`default_nettype none

module dqs_ffs #(
    parameter int N = dqs_pkg::CAPACITY_DEF
) (
    input  wire logic [N-1:0]         i_match,
    output logic                      o_found,
    output logic [$clog2(N)-1:0]      o_index
);
    import dqs_pkg::*;

    localparam int L = $clog2(N);
    localparam int P = 1 << L;

    logic [P-1:0]         lvl_v   [L+1];
    logic [P-1:0][L-1:0]  lvl_idx [L+1];

    assign lvl_v[0]   = P'(i_match);
    assign lvl_idx[0] = '0;

    for (genvar k = 0; k < L; k++) begin : g_lvl
        for (genvar j = 0; j < P; j++) begin : g_node
            if (j < (P >> (k + 1))) begin : g_used
                assign lvl_v[k+1][j] = lvl_v[k][2*j] | lvl_v[k][2*j+1];
                assign lvl_idx[k+1][j] = lvl_v[k][2*j] ? lvl_idx[k][2*j]
                                       : (lvl_idx[k][2*j+1] | (L'(1) << k));
            end else begin : g_pad
                assign lvl_v[k+1][j]   = 1'b0;
                assign lvl_idx[k+1][j] = '0;
            end
        end
    end

    assign o_found = lvl_v[L][0];
    assign o_index = lvl_idx[L][0];

endmodule

`default_nettype wire

// ----- tb/deque_search_checker.sv -----
`timescale 1ns / 100ps
// result checker for double_ended_queue_with_search: keeps its own copy of the store,
// predicts each request's result and compares it with every output transfer
// depends on dqs_pkg
module deque_search_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic [dqs_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [dqs_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [dqs_pkg::STATUS_W-1:0]  i_status,
    input  wire logic [dqs_pkg::POS_W-1:0]     i_found_index,
    input  wire logic [dqs_pkg::POS_W-1:0]     i_occupancy_now,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_request_count,
    output int                                 o_found_count,
    output int                                 o_miss_count,
    output int                                 o_empty_count,
    output int                                 o_full_count
);

    localparam int DEPTH = dqs_pkg::CAPACITY_DEF;
    localparam int PW    = dqs_pkg::POS_W;

    typedef struct packed {
        dqs_pkg::t_status  status;
        logic [PW-1:0]     index;
        logic [PW-1:0]     occ;
    } t_deque_result;

    logic [dqs_pkg::VALUE_W-1:0] model_cells [DEPTH];
    int                          model_occ = 0;
    t_deque_result               awaited_results [$];

    int fail_count    = 0;
    int pending_count = 0;
    int request_count = 0;
    int found_count   = 0;
    int miss_count    = 0;
    int empty_count   = 0;
    int full_count    = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_count;
    assign o_request_count = request_count;
    assign o_found_count   = found_count;
    assign o_miss_count    = miss_count;
    assign o_empty_count   = empty_count;
    assign o_full_count    = full_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic t_deque_result serve_request(input logic [dqs_pkg::REQ_W-1:0] req,
                                                    input logic [dqs_pkg::VALUE_W-1:0] v);
        t_deque_result r;
        int            i;
        logic          hit;
        r.status = dqs_pkg::ST_OK;
        r.index  = '0;
        hit      = 1'b0;
        case (req)
            dqs_pkg::REQ_PUSH_FRONT: begin
                if (model_occ >= DEPTH) begin
                    r.status = dqs_pkg::ST_FULL;
                end else begin
                    for (i = model_occ; i > 0; i--) model_cells[i] = model_cells[i-1];
                    model_cells[0] = v;
                    model_occ++;
                end
            end
            dqs_pkg::REQ_PUSH_BACK: begin
                if (model_occ >= DEPTH) begin
                    r.status = dqs_pkg::ST_FULL;
                end else begin
                    model_cells[model_occ] = v;
                    model_occ++;
                end
            end
            dqs_pkg::REQ_DROP_FRONT: begin
                if (model_occ == 0) begin
                    r.status = dqs_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i < model_occ - 1; i++) model_cells[i] = model_cells[i+1];
                    model_occ--;
                end
            end
            dqs_pkg::REQ_DROP_BACK: begin
                if (model_occ == 0) r.status = dqs_pkg::ST_EMPTY;
                else model_occ--;
            end
            dqs_pkg::REQ_SEARCH: begin
                if (model_occ == 0) begin
                    r.status = dqs_pkg::ST_EMPTY;
                end else begin
                    r.status = dqs_pkg::ST_MISS;
                    for (i = 0; i < model_occ; i++) begin
                        if (!hit && model_cells[i] == v) begin
                            hit      = 1'b1;
                            r.status = dqs_pkg::ST_OK;
                            r.index  = PW'(i + 1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.occ = PW'(model_occ);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_deque_result want;
        if (!i_rst_n) begin
            model_occ = 0;
            awaited_results.delete();
            pending_count = 0;
        end else begin
            // request transfer
            if (i_in_valid && i_in_ready) begin
                want = serve_request(i_req_type, i_value);
                awaited_results.push_back(want);
                pending_count++;
                request_count++;
                if (i_req_type == dqs_pkg::REQ_SEARCH && want.status == dqs_pkg::ST_OK)
                    found_count++;
                if (want.status == dqs_pkg::ST_MISS)  miss_count++;
                if (want.status == dqs_pkg::ST_EMPTY) empty_count++;
                if (want.status == dqs_pkg::ST_FULL)  full_count++;
            end
            // result transfer
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing pending, status", i_status, 0);
                end else begin
                    want = awaited_results.pop_front();
                    pending_count--;
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_found_index !== want.index)
                        report_mismatch("found_index", i_found_index, want.index);
                    if (i_occupancy_now !== want.occ)
                        report_mismatch("occupancy_now", i_occupancy_now, want.occ);
                end
            end
        end
    end

endmodule

// ----- tb/tb_double_ended_queue_with_search.sv -----
`timescale 1ns / 100ps
// testbench top for double_ended_queue_with_search: directed and random request traffic
// with random sender gaps and receiver stalls; verdict from deque_search_checker
// depends on dqs_pkg, double_ended_queue_with_search and deque_search_checker
module tb_double_ended_queue_with_search;

    localparam int REQUEST_TARGET = 950;
    localparam int QUIET_TAIL     = 150;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int DEPTH          = dqs_pkg::CAPACITY_DEF;
    localparam int SPARE_LO       = int'(dqs_pkg::REQ_SEARCH) + 1;
    localparam int SPARE_HI       = (1 << dqs_pkg::REQ_W) - 1;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic [dqs_pkg::REQ_W-1:0]            req_type;
    logic signed [dqs_pkg::VALUE_W-1:0]   value_in;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [dqs_pkg::STATUS_W-1:0]         status;
    logic [dqs_pkg::POS_W-1:0]            found_index;
    logic [dqs_pkg::POS_W-1:0]            occ_now;

    int fail_count;
    int pending;
    int request_count;
    int found_count;
    int miss_count;
    int empty_count;
    int full_count;

    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;

    double_ended_queue_with_search i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_value         (value_in),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .o_found_index   (found_index),
        .o_occupancy_now (occ_now)
    );

    deque_search_checker u_result_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_value         (value_in),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_status        (status),
        .i_found_index   (found_index),
        .i_occupancy_now (occ_now),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_request_count (request_count),
        .o_found_count   (found_count),
        .o_miss_count    (miss_count),
        .o_empty_count   (empty_count),
        .o_full_count    (full_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still pending", CYCLE_LIMIT, pending);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver side: stall bursts and ready runs
    initial begin : result_sink
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    function automatic logic [dqs_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            4:       return 32'h0000_0001;
            5:       return 32'h5555_5555;
            6:       return 32'haaaa_aaaa;
            7:       return 32'h0000_002a;
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(input logic [dqs_pkg::REQ_W-1:0] req,
                                input logic [dqs_pkg::VALUE_W-1:0] v);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        value_in <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin : request_source
        int                        served;
        int                        phase_left;
        int                        pick;
        int                        k;
        bit                        filling;
        bit                        push_it;
        logic [dqs_pkg::REQ_W-1:0] req;
        logic [dqs_pkg::REQ_W-1:0] spare;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = dqs_pkg::REQ_PUSH_FRONT;
        value_in = '0;
        served     = 0;
        phase_left = 0;
        filling    = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // empty store cases and an unused code
        send_request(dqs_pkg::REQ_SEARCH, 32'h0000_0000);
        send_request(dqs_pkg::REQ_DROP_FRONT, 32'hffff_ffff);
        send_request(dqs_pkg::REQ_DROP_BACK, 32'h0000_0000);
        spare = dqs_pkg::REQ_W'(SPARE_HI);
        send_request(spare, 32'h1234_5678);
        // extremes at both ends
        send_request(dqs_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff);
        send_request(dqs_pkg::REQ_PUSH_BACK, 32'h8000_0000);
        send_request(dqs_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(dqs_pkg::REQ_SEARCH, 32'h8000_0000);
        send_request(dqs_pkg::REQ_SEARCH, 32'hffff_ffff);
        send_request(dqs_pkg::REQ_DROP_FRONT, 32'h0000_0000);
        send_request(dqs_pkg::REQ_DROP_BACK, 32'hffff_ffff);
        // fill to capacity with repeated values
        for (k = 1; k < DEPTH - 1; k++) begin
            send_request(k[0] ? dqs_pkg::REQ_PUSH_FRONT : dqs_pkg::REQ_PUSH_BACK, k % 4);
        end
        send_request(dqs_pkg::REQ_PUSH_BACK, 32'hdead_beef);
        send_request(dqs_pkg::REQ_PUSH_FRONT, 32'h0000_0005);
        send_request(dqs_pkg::REQ_PUSH_BACK, 32'h0000_0006);
        send_request(dqs_pkg::REQ_SEARCH, 32'hdead_beef);
        send_request(dqs_pkg::REQ_SEARCH, 32'h0000_0002);

        // random traffic in fill and drain phases
        while (served < REQUEST_TARGET) begin
            if (phase_left == 0) begin
                filling    = 1'($urandom_range(0, 1));
                phase_left = $urandom_range(10, 50);
                gaps_on    = ($urandom_range(0, 2) != 0);
                stalls_on  = ($urandom_range(0, 2) != 0);
            end
            if (served >= REQUEST_TARGET - QUIET_TAIL) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                spare = dqs_pkg::REQ_W'($urandom_range(SPARE_HI, SPARE_LO));
                send_request(spare, $urandom());
            end else begin
                if (pick < 25) begin
                    req = dqs_pkg::REQ_SEARCH;
                end else begin
                    push_it = filling ? (pick < 80) : (pick >= 80);
                    if (push_it)
                        req = $urandom_range(0, 1) ? dqs_pkg::REQ_PUSH_FRONT
                                                   : dqs_pkg::REQ_PUSH_BACK;
                    else
                        req = $urandom_range(0, 1) ? dqs_pkg::REQ_DROP_FRONT
                                                   : dqs_pkg::REQ_DROP_BACK;
                end
                send_request(req, pick_value());
                served++;
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d requests: %0d searches found, %0d misses",
                 request_count, found_count, miss_count);
        $display("empty store hit %0d times, full store refused %0d pushes",
                 empty_count, full_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- double_ended_queue_with_search.f -----
sv/dqs_pkg.sv
sv/dqs_cell.sv
sv/dqs_ffs.sv
sv/double_ended_queue_with_search.sv
tb/deque_search_checker.sv
tb/tb_double_ended_queue_with_search.sv
